FILE: rtl/core/rgb_to_hsv_pixel_converter_defines.svh
// Assertion macros used by the divider of the RGB to HSV converter RTL.
`ifndef RGB_TO_HSV_PIXEL_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_CONVERTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising edge of clk outside reset.
`define RHSV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define RHSV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RHSV_ASSERT(lbl, prop, msg)
`define RHSV_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/core/rhsv_pkg.sv
// Package with the shared constants of the RGB to HSV converter.
`timescale 1ns / 1ps
`default_nettype none
package rhsv_pkg;
    localparam int FRAC_BITS_DEF = 12;
    localparam int SECTOR_GREEN = 2;
    localparam int SECTOR_BLUE = 4;
    localparam int SECTORS = 6;
endpackage
`default_nettype wire

FILE: rtl/core/rhsv_div_pipe.sv
// Two-lane pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_hsv_pixel_converter_defines.svh"
module rhsv_div_pipe #(
    parameter int FRAC_BITS = rhsv_pkg::FRAC_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [FRAC_BITS+3:0]   hue_num,
    input  wire logic [FRAC_BITS+3:0]   hue_den,
    input  wire logic [FRAC_BITS:0]     sat_num,
    input  wire logic [FRAC_BITS:0]     sat_den,
    input  wire logic [FRAC_BITS:0]     bright_in,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [FRAC_BITS-1:0]        hue,
    output logic [FRAC_BITS:0]          saturation,
    output logic [FRAC_BITS:0]          brightness
);
    import rhsv_pkg::*;

    localparam int IW  = FRAC_BITS + 1;
    localparam int HW  = FRAC_BITS + 4;
    localparam int NST = FRAC_BITS + 1;
    localparam int LST = NST - 1;

    logic          vld_reg [NST];
    logic          rdy     [NST];
    logic [HW:0]   hr_reg  [NST];
    logic [HW-1:0] hd_reg  [NST];
    logic [FRAC_BITS:0] hq_reg [NST];
    logic [IW:0]   sr_reg  [NST];
    logic [IW-1:0] sd_reg  [NST];
    logic [FRAC_BITS:0] sq_reg [NST];
    logic [IW-1:0] v_reg   [NST];

    genvar i;
    generate
        for (i = 0; i < NST; i++)
        begin : g_stage
            logic          prev_vld;
            logic          next_rdy;
            logic [HW:0]   h_src;
            logic [HW:0]   h_trial;
            logic [HW-1:0] h_den;
            logic [FRAC_BITS:0] h_qp;
            logic [IW:0]   s_src;
            logic [IW:0]   s_trial;
            logic [IW-1:0] s_den;
            logic [FRAC_BITS:0] s_qp;
            logic [IW-1:0] v_src;
            logic          h_ge;
            logic          s_ge;

            if (i == 0)
            begin : g_first
                assign prev_vld = in_valid;
                assign h_src    = {1'b0, hue_num};
                assign h_den    = hue_den;
                assign h_qp     = '0;
                assign s_src    = {1'b0, sat_num};
                assign s_den    = sat_den;
                assign s_qp     = '0;
                assign v_src    = bright_in;
                // The first stage tests the unshifted numerator for a whole quotient of one.
                assign h_trial  = h_src;
                assign s_trial  = s_src;
            end
            else
            begin : g_rest
                assign prev_vld = vld_reg[i-1];
                assign h_src    = hr_reg[i-1];
                assign h_den    = hd_reg[i-1];
                assign h_qp     = hq_reg[i-1];
                assign s_src    = sr_reg[i-1];
                assign s_den    = sd_reg[i-1];
                assign s_qp     = sq_reg[i-1];
                assign v_src    = v_reg[i-1];
                assign h_trial  = {h_src[HW-1:0], 1'b0};
                assign s_trial  = {s_src[IW-1:0], 1'b0};
            end

            if (i == LST)
            begin : g_last
                assign next_rdy = out_ready;
            end
            else
            begin : g_mid
                assign next_rdy = rdy[i+1];
            end

            assign rdy[i] = !vld_reg[i] || next_rdy;
            assign h_ge   = h_trial >= {1'b0, h_den};
            assign s_ge   = s_trial >= {1'b0, s_den};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else if (rdy[i])
                begin
                    vld_reg[i] <= prev_vld;
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[i] && prev_vld)
                begin
                    hr_reg[i] <= h_ge ? (h_trial - {1'b0, h_den}) : h_trial;
                    hd_reg[i] <= h_den;
                    hq_reg[i] <= {h_qp[FRAC_BITS-1:0], h_ge};
                    sr_reg[i] <= s_ge ? (s_trial - {1'b0, s_den}) : s_trial;
                    sd_reg[i] <= s_den;
                    sq_reg[i] <= {s_qp[FRAC_BITS-1:0], s_ge};
                    v_reg[i]  <= v_src;
                end
            end
        end
    endgenerate

    assign in_ready   = rdy[0];
    assign out_valid  = vld_reg[LST];
    assign hue        = hq_reg[LST][FRAC_BITS-1:0];
    assign saturation = sq_reg[LST];
    assign brightness = v_reg[LST];

    `RHSV_ASSERT(a_hold, vld_reg[LST] && !out_ready |=> vld_reg[LST], "stalled result dropped")
    `RHSV_ASSERT(a_hue_rng, vld_reg[LST] |-> !hq_reg[LST][FRAC_BITS], "hue quotient reached one")
    `RHSV_ASSERT(a_sat_rng, vld_reg[LST] |-> (sq_reg[LST] <= (1 << FRAC_BITS)), "saturation above one")
    `RHSV_ASSERT(a_enter, in_valid && in_ready |=> vld_reg[0], "accepted beat not captured")
endmodule
`default_nettype wire

FILE: rtl/core/rgb_to_hsv_pixel_converter.sv
// Top level of the RGB to HSV pixel converter.
`timescale 1ns / 1ps
`default_nettype none
// Converts one RGB pixel per clock into hue, saturation and brightness. A beat
// enters every cycle unless back-pressure reaches the input stage. Each result
// passes through one register stage for max, min and sector selection followed
// by a divider that resolves one quotient bit per stage for hue and saturation
// side by side. Every stage holds its beat under back-pressure while empty
// stages upstream keep filling. Ties for the maximum favour blue, then green.
module rgb_to_hsv_pixel_converter #(
    parameter int FRAC_BITS = rhsv_pkg::FRAC_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // red, green, blue (FRAC_BITS+1 bits each), zero padding
    input  wire logic [((3*(FRAC_BITS+1)+7)/8)*8-1:0] s_axis_tdata,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // hue (FRAC_BITS bits), saturation, brightness (FRAC_BITS+1 bits each), zero padding
    output logic [((3*FRAC_BITS+2+7)/8)*8-1:0] m_axis_tdata
);
    import rhsv_pkg::*;

    localparam int IW   = FRAC_BITS + 1;
    localparam int HW   = FRAC_BITS + 4;
    localparam int OW   = 3 * FRAC_BITS + 2;
    localparam int OTDW = ((OW + 7) / 8) * 8;

    logic [IW-1:0] red, green, blue;
    logic [IW-1:0] vmax, vmin, chroma;
    logic [HW-1:0] c_ext, c6, t_val;
    logic [HW-1:0] hn_next, hd_next;
    logic [IW-1:0] sd_next;

    logic          f_vld_reg;
    logic [HW-1:0] hn_reg, hd_reg;
    logic [IW-1:0] sn_reg, sd_reg, v_reg;
    logic          f_rdy, div_rdy;

    logic [FRAC_BITS-1:0] hue;
    logic [IW-1:0]        saturation, brightness;

    assign red   = s_axis_tdata[IW-1:0];
    assign green = s_axis_tdata[2*IW-1:IW];
    assign blue  = s_axis_tdata[3*IW-1:2*IW];

    always_comb
    begin
        vmax = red;
        if (green > vmax) vmax = green;
        if (blue > vmax) vmax = blue;
        vmin = red;
        if (green < vmin) vmin = green;
        if (blue < vmin) vmin = blue;
        chroma = vmax - vmin;
        c_ext  = {3'b000, chroma};
        c6     = HW'(c_ext * SECTORS);
        // Sums are taken modulo the lane width; the true value always lies in [0, 6C).
        if (vmax == blue)
        begin
            t_val = {3'b000, red} - {3'b000, green} + HW'(c_ext * SECTOR_BLUE);
        end
        else if (vmax == green)
        begin
            t_val = {3'b000, blue} - {3'b000, red} + HW'(c_ext * SECTOR_GREEN);
        end
        else if (green < blue)
        begin
            t_val = {3'b000, green} + c6 - {3'b000, blue};
        end
        else
        begin
            t_val = {3'b000, green} - {3'b000, blue};
        end
        // A gray or black pixel divides zero by one so the quotient comes out zero.
        if (chroma == '0)
        begin
            hn_next = '0;
            hd_next = HW'(1);
        end
        else
        begin
            hn_next = t_val;
            hd_next = c6;
        end
        sd_next = (vmax == '0) ? IW'(1) : vmax;
    end

    assign f_rdy         = !f_vld_reg || div_rdy;
    assign s_axis_tready = f_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else if (f_rdy)
        begin
            f_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_rdy && s_axis_tvalid)
        begin
            hn_reg <= hn_next;
            hd_reg <= hd_next;
            sn_reg <= chroma;
            sd_reg <= sd_next;
            v_reg  <= vmax;
        end
    end

    rhsv_div_pipe #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (f_vld_reg),
        .in_ready   (div_rdy),
        .hue_num    (hn_reg),
        .hue_den    (hd_reg),
        .sat_num    (sn_reg),
        .sat_den    (sd_reg),
        .bright_in  (v_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    assign m_axis_tdata = OTDW'({brightness, saturation, hue});
endmodule
`default_nettype wire

FILE: tb/sv/rgb_to_hsv_pixel_converter_test.sv
// Self-checking testbench for the RGB to HSV pixel converter.
`timescale 1ns / 1ps
module rgb_to_hsv_pixel_converter_test;
    localparam int FB = rhsv_pkg::FRAC_BITS_DEF;
    localparam int IW = FB + 1;
    localparam int SW = ((3 * IW + 7) / 8) * 8;
    localparam int MW = ((3 * FB + 2 + 7) / 8) * 8;
    localparam int LATENCY = FB + 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM = 600;
    localparam int N_DIRECTED = 20;

    typedef struct packed {
        logic [FB-1:0] hue;
        logic [IW-1:0] sat;
        logic [IW-1:0] val;
    } hsv_t;

    typedef struct {
        logic [IW-1:0] r;
        logic [IW-1:0] g;
        logic [IW-1:0] b;
        bit            known;
        hsv_t          hsv;
    } pixel_row_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [SW-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [MW-1:0] m_axis_tdata;

    hsv_t pending_hsv[$];
    int mismatches;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;
    pixel_row_t pixel_table[N_DIRECTED];

    rgb_to_hsv_pixel_converter DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    function automatic hsv_t convert_pixel(logic [IW-1:0] r, logic [IW-1:0] g,
                                           logic [IW-1:0] b);
        longint rr;
        longint gg;
        longint bb;
        longint v;
        longint lo;
        longint c;
        longint t;
        hsv_t o;
        rr = r;
        gg = g;
        bb = b;
        v = rr;
        lo = rr;
        if (gg > v) v = gg;
        if (bb > v) v = bb;
        if (gg < lo) lo = gg;
        if (bb < lo) lo = bb;
        c = v - lo;
        o.val = v[IW-1:0];
        o.sat = (v != 0) ? IW'((c << FB) / v) : '0;
        o.hue = '0;
        if (c != 0)
        begin
            if (v == bb)
                t = (rr - gg) + rhsv_pkg::SECTOR_BLUE * c;
            else if (v == gg)
                t = (bb - rr) + rhsv_pkg::SECTOR_GREEN * c;
            else
            begin
                t = gg - bb;
                if (t < 0) t += rhsv_pkg::SECTORS * c;
            end
            o.hue = FB'((t << FB) / (rhsv_pkg::SECTORS * c));
        end
        return o;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Results are compared at the rising edge against the oldest prediction.
    always @(posedge clk)
    begin
        hsv_t got;
        hsv_t want;
        cycles <= cycles + 1;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            // Hue sits in the lowest bits of the beat, brightness in the highest.
            got.hue = m_axis_tdata[FB-1:0];
            got.sat = m_axis_tdata[FB+IW-1:FB];
            got.val = m_axis_tdata[FB+2*IW-1:FB+IW];
            if (pending_hsv.size() == 0)
            begin
                if (mismatches < 10) $display("unexpected beat %h", got);
                mismatches++;
            end
            else
            begin
                want = pending_hsv.pop_front();
                if (got.hue !== want.hue || got.sat !== want.sat || got.val !== want.val)
                begin
                    if (mismatches < 10)
                        $display("mismatch: hue %0d/%0d sat %0d/%0d val %0d/%0d (exp/act)",
                                 want.hue, got.hue, want.sat, got.sat, want.val, got.val);
                    mismatches++;
                end
            end
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge clk)
        m_axis_tready <= !rst_n || ($urandom_range(99) >= recv_idle_pct);

    task automatic send_pixel(logic [IW-1:0] r, logic [IW-1:0] g, logic [IW-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= SW'({b, g, r});
        pending_hsv.push_back(convert_pixel(r, g, b));
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [IW-1:0] random_channel();
        case ($urandom_range(9))
            0: return '0;
            1: return IW'(1 << FB);
            2: return IW'($urandom_range((1 << IW) - 1));
            default: return IW'($urandom_range(1 << FB));
        endcase
    endfunction

    initial
    begin
        logic [IW-1:0] r;
        logic [IW-1:0] g;
        logic [IW-1:0] b;
        hsv_t want;
        int i;
        int phase;
        // Expected values are filled in for black, white, the primaries and an over-range gray only.
        pixel_table[0] = '{0, 0, 0, 1, '{0, 0, 0}};
        pixel_table[1] = '{4096, 4096, 4096, 1, '{0, 0, 4096}};
        pixel_table[2] = '{4096, 0, 0, 1, '{0, 4096, 4096}};
        pixel_table[3] = '{0, 4096, 0, 1, '{1365, 4096, 4096}};
        pixel_table[4] = '{0, 0, 4096, 1, '{2730, 4096, 4096}};
        pixel_table[5] = '{8191, 8191, 8191, 1, '{0, 0, 8191}};
        pixel_table[6] = '{4096, 4096, 0, 0, '{0, 0, 0}};
        pixel_table[7] = '{0, 4096, 4096, 0, '{0, 0, 0}};
        pixel_table[8] = '{4096, 0, 4096, 0, '{0, 0, 0}};
        pixel_table[9] = '{4096, 0, 1, 0, '{0, 0, 0}};
        pixel_table[10] = '{1, 0, 0, 0, '{0, 0, 0}};
        pixel_table[11] = '{8191, 0, 4096, 0, '{0, 0, 0}};
        pixel_table[12] = '{0, 8191, 1, 0, '{0, 0, 0}};
        pixel_table[13] = '{5461, 2730, 8191, 0, '{0, 0, 0}};
        pixel_table[14] = '{2048, 2048, 2048, 0, '{0, 0, 0}};
        pixel_table[15] = '{4095, 4096, 4095, 0, '{0, 0, 0}};
        pixel_table[16] = '{1, 2, 3, 0, '{0, 0, 0}};
        pixel_table[17] = '{8191, 8190, 0, 0, '{0, 0, 0}};
        pixel_table[18] = '{3000, 1000, 2000, 0, '{0, 0, 0}};
        pixel_table[19] = '{1, 1, 0, 0, '{0, 0, 0}};
        cycles = 0;
        mismatches = 0;
        send_idle_pct = 19;
        recv_idle_pct = 73;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (i = 0; i < N_DIRECTED; i++)
        begin
            if (pixel_table[i].known)
            begin
                want = convert_pixel(pixel_table[i].r, pixel_table[i].g, pixel_table[i].b);
                if (want !== pixel_table[i].hsv)
                begin
                    if (mismatches < 10) $display("table row %0d disagrees", i);
                    mismatches++;
                end
            end
            send_pixel(pixel_table[i].r, pixel_table[i].g, pixel_table[i].b);
        end
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 73 : 0;
            recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 19 : 0;
            for (i = 0; i < N_RANDOM / 3; i++)
            begin
                r = random_channel();
                g = random_channel();
                b = random_channel();
                // Ties for the maximum are forced now and then.
                case ($urandom_range(7))
                    0: g = r;
                    1: b = g;
                    2: b = r;
                    default: ;
                endcase
                send_pixel(r, g, b);
                if (i == 50)
                begin
                    // Let the pipeline drain completely before carrying on.
                    s_axis_tvalid <= 1'b0;
                    while (pending_hsv.size() != 0) @(negedge clk);
                end
            end
        end
        s_axis_tvalid <= 1'b0;
        while (pending_hsv.size() != 0) @(negedge clk);
        repeat (LATENCY * 2) @(negedge clk);
        if (mismatches == 0 && pending_hsv.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/rhsv_pkg.sv
rtl/core/rhsv_div_pipe.sv
rtl/core/rgb_to_hsv_pixel_converter.sv
tb/sv/rgb_to_hsv_pixel_converter_test.sv
